### sv/sgcd_pkg.sv
// Shared types, codes and reset values for the stick gesture code detector.
`default_nettype none

package sgcd_pkg;

  // Number of strokes held in the history and compared with each code.
  localparam int unsigned CODE_LENGTH = 7;

  // Field widths of the stream words and configuration registers.
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COOLDOWN_W = 16;
  localparam int unsigned CODE_W     = 21;
  localparam int unsigned STROKE_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 21;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 8;

  // Register values after reset.
  localparam logic [SAMPLE_W-1:0]   CENTER_RESET   = 12'd1500;
  localparam logic [SAMPLE_W-1:0]   BAND_RESET     = 12'd150;
  localparam logic [COOLDOWN_W-1:0] COOLDOWN_RESET = 16'd600;
  localparam logic [CODE_W-1:0]     CODE_A_RESET   = 21'd1156753;
  localparam logic [CODE_W-1:0]     CODE_B_RESET   = 21'd866466;

  // Stroke codes.
  typedef enum logic [STROKE_W-1:0] {
    STROKE_NONE  = 3'd0,
    STROKE_UP    = 3'd1,
    STROKE_DOWN  = 3'd2,
    STROKE_LEFT  = 3'd3,
    STROKE_RIGHT = 3'd4
  } stroke_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_CH1   = 3'd0,
    REG_CENTER_CH2   = 3'd1,
    REG_NEUTRAL_BAND = 3'd2,
    REG_COOLDOWN_MS  = 3'd3,
    REG_CODE_A       = 3'd4,
    REG_CODE_B       = 3'd5
  } cfg_reg_e;

  // Outcome of the history update for one word.
  typedef struct packed {
    logic accepted;
    logic match_a;
    logic match_b;
  } match_t;

endpackage

`default_nettype wire

### sv/sgcd_classify.sv
// Stroke classifier: offsets from the centres, neutral band test and direction choice.
`default_nettype none

module sgcd_classify (
  input  wire logic [sgcd_pkg::SAMPLE_W-1:0] sample_ch1_i,
  input  wire logic [sgcd_pkg::SAMPLE_W-1:0] sample_ch2_i,
  input  wire logic [sgcd_pkg::SAMPLE_W-1:0] center_ch1_i,
  input  wire logic [sgcd_pkg::SAMPLE_W-1:0] center_ch2_i,
  input  wire logic [sgcd_pkg::SAMPLE_W-1:0] neutral_band_i,
  output sgcd_pkg::stroke_e                  stroke_o
);

  logic [sgcd_pkg::SAMPLE_W:0]   diff1, diff2;
  logic [sgcd_pkg::SAMPLE_W:0]   neg1, neg2;
  logic [sgcd_pkg::SAMPLE_W-1:0] mag1, mag2;
  logic                          pos1, pos2;

  // Signed offsets, one bit wider than the samples.
  assign diff1 = {1'b0, sample_ch1_i} - {1'b0, center_ch1_i};
  assign diff2 = {1'b0, sample_ch2_i} - {1'b0, center_ch2_i};
  assign neg1  = -diff1;
  assign neg2  = -diff2;

  // Magnitudes always fit the sample width.
  assign mag1 = diff1[sgcd_pkg::SAMPLE_W] ? neg1[sgcd_pkg::SAMPLE_W-1:0]
                                          : diff1[sgcd_pkg::SAMPLE_W-1:0];
  assign mag2 = diff2[sgcd_pkg::SAMPLE_W] ? neg2[sgcd_pkg::SAMPLE_W-1:0]
                                          : diff2[sgcd_pkg::SAMPLE_W-1:0];
  assign pos1 = !diff1[sgcd_pkg::SAMPLE_W] && (diff1 != '0);
  assign pos2 = !diff2[sgcd_pkg::SAMPLE_W] && (diff2 != '0);

  // Both inside the band is neutral; otherwise the larger offset wins, a tie goes to channel two.
  always_comb begin
    if ((mag1 < neutral_band_i) && (mag2 < neutral_band_i)) begin
      stroke_o = sgcd_pkg::STROKE_NONE;
    end else if (mag1 > mag2) begin
      stroke_o = pos1 ? sgcd_pkg::STROKE_UP : sgcd_pkg::STROKE_DOWN;
    end else begin
      stroke_o = pos2 ? sgcd_pkg::STROKE_RIGHT : sgcd_pkg::STROKE_LEFT;
    end
  end

endmodule

`default_nettype wire

### sv/sgcd_history.sv
// Stroke history, cooldown timer state and comparison with the two codes.
`default_nettype none

module sgcd_history #(
  parameter int unsigned CodeLength = sgcd_pkg::CODE_LENGTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            update_i,
  input  wire sgcd_pkg::stroke_e               stroke_i,
  input  wire logic [sgcd_pkg::TIME_W-1:0]     now_ms_i,
  input  wire logic [sgcd_pkg::COOLDOWN_W-1:0] cooldown_ms_i,
  input  wire logic [sgcd_pkg::CODE_W-1:0]     code_a_i,
  input  wire logic [sgcd_pkg::CODE_W-1:0]     code_b_i,
  output sgcd_pkg::match_t                     result_o
);

  localparam int unsigned HistW = sgcd_pkg::STROKE_W * CodeLength;
  localparam int unsigned ExtW  = (HistW > sgcd_pkg::CODE_W) ? HistW : sgcd_pkg::CODE_W;

  logic [HistW-1:0]           hist_q, hist_d;
  logic [sgcd_pkg::TIME_W-1:0] last_q;
  logic [sgcd_pkg::TIME_W-1:0] elapsed;
  logic [ExtW-1:0]            code_a_ext, code_b_ext;
  logic                       take;

  // Cooldown test on the wrapped time difference.
  assign elapsed = now_ms_i - last_q;
  assign take    = (stroke_i != sgcd_pkg::STROKE_NONE) &&
                   (elapsed >= sgcd_pkg::TIME_W'(cooldown_ms_i));

  // Oldest stroke sits in the low bits; a new stroke enters at the top.
  assign hist_d = take ? {stroke_i, hist_q[HistW-1:sgcd_pkg::STROKE_W]} : hist_q;

  // Code bits beyond the register width read as zero.
  assign code_a_ext = ExtW'(code_a_i);
  assign code_b_ext = ExtW'(code_b_i);

  assign result_o.accepted = take;
  assign result_o.match_a  = (hist_d == code_a_ext[HistW-1:0]);
  assign result_o.match_b  = (hist_d == code_b_ext[HistW-1:0]);

  // State moves only when the word is handed on to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      last_q <= '0;
    end else if (update_i && take) begin
      hist_q <= hist_d;
      last_q <= now_ms_i;
    end
  end

`ifndef SYNTH
  // A neutral stroke is never taken into the history.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.accepted |-> (stroke_i != sgcd_pkg::STROKE_NONE))
    else $error("neutral stroke accepted");

  // A taken stroke records its timestamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (update_i && result_o.accepted) |=> (last_q == $past(now_ms_i)))
    else $error("last accept time not recorded");

  // Without a taken stroke the history keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(update_i && result_o.accepted) |=> $stable(hist_q))
    else $error("history changed without an accepted stroke");
`endif

endmodule

`default_nettype wire

### sv/stick_gesture_code_detector.sv
// Top level of the stick gesture code detector: stream stages and configuration registers.
//
// Input words arrive on the s_axis channel, one per accepted handshake, each carrying
// both stick samples and a millisecond timestamp. Every input word produces exactly one
// result word on the m_axis channel: the classified stroke, whether it entered the
// history, and whether the history now matches code A or code B.
// The block has an input register and a result register with the classifier, the
// cooldown test and the code comparison between them. A result word passes from the
// input register into the result register and then appears on m_axis; one word can be
// taken every cycle while the receiver keeps m_axis_tready high.
// When the receiver holds m_axis_tready low the result register holds its word; the
// input register still takes one more word, then s_axis_tready falls until the result
// register drains. Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i
// with no read-back; indexes beyond the last register are ignored.
// Reset empties both stages, clears the history to neutral strokes and the last accept
// time to zero, and loads the default centres, band, cooldown and codes.
`default_nettype none

module stick_gesture_code_detector #(
  parameter int unsigned CodeLength = sgcd_pkg::CODE_LENGTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input stream.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_ch1 [11:0], sample_ch2 [23:12], now_ms [55:24]
  input  wire logic [sgcd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // stroke [2:0], accepted [3], match_a [4], match_b [5], zero [7:6]
  output logic [sgcd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic [sgcd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sgcd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [sgcd_pkg::SAMPLE_W-1:0]   center_ch1_q, center_ch2_q, band_q;
  logic [sgcd_pkg::COOLDOWN_W-1:0] cooldown_q;
  logic [sgcd_pkg::CODE_W-1:0]     code_a_q, code_b_q;

  logic                            in_valid_q, in_valid_d;
  logic [sgcd_pkg::IN_DATA_W-1:0]  in_data_q;
  logic                            out_valid_q, out_valid_d;
  logic [sgcd_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                            out_free, advance, in_take;
  sgcd_pkg::stroke_e               stroke;
  sgcd_pkg::match_t                result;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_ch1_q <= sgcd_pkg::CENTER_RESET;
      center_ch2_q <= sgcd_pkg::CENTER_RESET;
      band_q       <= sgcd_pkg::BAND_RESET;
      cooldown_q   <= sgcd_pkg::COOLDOWN_RESET;
      code_a_q     <= sgcd_pkg::CODE_A_RESET;
      code_b_q     <= sgcd_pkg::CODE_B_RESET;
    end else if (cfg_we_i) begin
      case (sgcd_pkg::cfg_reg_e'(cfg_idx_i))
        sgcd_pkg::REG_CENTER_CH1:   center_ch1_q <= cfg_data_i[sgcd_pkg::SAMPLE_W-1:0];
        sgcd_pkg::REG_CENTER_CH2:   center_ch2_q <= cfg_data_i[sgcd_pkg::SAMPLE_W-1:0];
        sgcd_pkg::REG_NEUTRAL_BAND: band_q       <= cfg_data_i[sgcd_pkg::SAMPLE_W-1:0];
        sgcd_pkg::REG_COOLDOWN_MS:  cooldown_q   <= cfg_data_i[sgcd_pkg::COOLDOWN_W-1:0];
        sgcd_pkg::REG_CODE_A:       code_a_q     <= cfg_data_i[sgcd_pkg::CODE_W-1:0];
        sgcd_pkg::REG_CODE_B:       code_b_q     <= cfg_data_i[sgcd_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake: the input word moves on whenever the result register can take it.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input word register.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata;
    end
  end

  sgcd_classify u_classify (
    .sample_ch1_i   (in_data_q[11:0]),
    .sample_ch2_i   (in_data_q[23:12]),
    .center_ch1_i   (center_ch1_q),
    .center_ch2_i   (center_ch2_q),
    .neutral_band_i (band_q),
    .stroke_o       (stroke)
  );

  sgcd_history #(
    .CodeLength (CodeLength)
  ) u_history (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .update_i      (advance),
    .stroke_i      (stroke),
    .now_ms_i      (in_data_q[55:24]),
    .cooldown_ms_i (cooldown_q),
    .code_a_i      (code_a_q),
    .code_b_i      (code_b_q),
    .result_o      (result)
  );

  // Result word register.
  assign out_data_d = {2'b00, result.match_b, result.match_a, result.accepted, stroke};

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  // An empty input register always takes a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stage empty but not ready");

  // A word handed on appears in the result register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (m_axis_tvalid && (m_axis_tdata == $past(out_data_d))))
    else $error("result word lost");

  // A result that is held back keeps the input stage from being overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |-> !s_axis_tready)
    else $error("input stage overrun while result stalled");
`endif

endmodule

`default_nettype wire
